// File: src/mpbs_pkg.sv
// package for the multipart boundary scanner: codes, constants and types
`timescale 1ns / 1ps
`default_nettype none
package mpbs_pkg;

  localparam int unsigned MAX_BOUNDARY_BYTES = 56;
  localparam int unsigned COUNT_BITS_DEFAULT = 24;
  localparam int unsigned BOUNDARY_WORDS     = 7;
  localparam int unsigned REG_BITS           = 64;
  localparam int unsigned ADDR_BITS          = 6;
  localparam int unsigned LEN_BITS           = 24;
  localparam int unsigned BLEN_BITS          = 6;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_DASH = 8'h2d;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  // register indexes, byte address is 8 times the index
  typedef enum logic [2:0] {
    REG_BOUNDARY_LENGTH = 3'd0,
    REG_BOUNDARY_WORD_0 = 3'd1,
    REG_BOUNDARY_WORD_1 = 3'd2,
    REG_BOUNDARY_WORD_2 = 3'd3,
    REG_BOUNDARY_WORD_3 = 3'd4,
    REG_BOUNDARY_WORD_4 = 3'd5,
    REG_BOUNDARY_WORD_5 = 3'd6,
    REG_BOUNDARY_WORD_6 = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_PARSING   = 3'd0,
    PH_EXPECT_LF = 3'd1,
    PH_DASH1     = 3'd2,
    PH_DASH2     = 3'd3,
    PH_BOUNDARY  = 3'd4
  } scan_phase_t;

  typedef enum logic [1:0] {
    ST_SCANNING = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2
  } scan_status_t;

  typedef struct packed {
    scan_status_t        status;
    logic [LEN_BITS-1:0] content_length;
  } scan_result_t;

endpackage
`default_nettype wire

// File: src/multipart_boundary_scanner_unit.sv
// top level of the multipart boundary scanner: delimiter match, counters, output skid
`timescale 1ns / 1ps
`default_nettype none
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast buffer_end
// m_*       out  m_tvalid/m_tready  m_tdata[23:0] content_length, m_tuser[1:0] scan_status
// apb       in   psel/penable/pwrite/pready  paddr[5:3] register index, pwdata 64 bits
//
// one byte per cycle while s_tready is high: each byte is decoded against the scan state and its
// result is registered into the output register, or into the skid while the output stalls
// a skid register behind the output register keeps s_tready high for one extra
// transaction while m_tready is low; s_tready then drops until the skid drains
// rst clears the scan state, the boundary words and both valid flags, and sets the boundary length to 1
//
module multipart_boundary_scanner_unit #(
  parameter int unsigned COUNT_BITS = mpbs_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave side
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  wire logic                           s_tlast,   // buffer_end
  // master side
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [mpbs_pkg::LEN_BITS-1:0]       m_tdata,   // [23:0] content_length
  output logic [1:0]                          m_tuser,   // [1:0] scan_status
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpbs_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [mpbs_pkg::REG_BITS-1:0]  pwdata,
  output logic [mpbs_pkg::REG_BITS-1:0]       prdata,
  output logic                                pready
);
  import mpbs_pkg::*;

  localparam int unsigned EXT_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [BLEN_BITS-1:0] boundary_length;
  logic [REG_BITS-1:0]  boundary_word [BOUNDARY_WORDS];

  // scan state
  scan_phase_t           scan_phase, scan_phase_next;
  logic [BLEN_BITS-1:0]  match_index, match_index_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [COUNT_BITS-1:0] last_cr_position, last_cr_position_next;

  // output register and skid
  logic         out_valid, skid_valid;
  scan_result_t out_data, skid_data;
  scan_result_t result;

  logic       in_accept;
  logic       cfg_write;
  reg_index_t cfg_index;

  logic [7:0]           data_byte;
  logic                 buffer_end;
  logic                 is_cr, is_lf, is_dash;
  logic [BLEN_BITS-1:0] len_used;
  logic [2:0]           word_sel;
  logic [7:0]           bnd_byte;
  logic [BLEN_BITS:0]   match_inc;
  logic                 found;
  logic [EXT_BITS-1:0]  cr_ext;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_length <= BLEN_BITS'(1);
      for (int w = 0; w < BOUNDARY_WORDS; w++) begin
        boundary_word[w] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOUNDARY_LENGTH: boundary_length <= pwdata[BLEN_BITS-1:0];
        REG_BOUNDARY_WORD_0: boundary_word[0] <= pwdata;
        REG_BOUNDARY_WORD_1: boundary_word[1] <= pwdata;
        REG_BOUNDARY_WORD_2: boundary_word[2] <= pwdata;
        REG_BOUNDARY_WORD_3: boundary_word[3] <= pwdata;
        REG_BOUNDARY_WORD_4: boundary_word[4] <= pwdata;
        REG_BOUNDARY_WORD_5: boundary_word[5] <= pwdata;
        REG_BOUNDARY_WORD_6: boundary_word[6] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_BOUNDARY_LENGTH: prdata = REG_BITS'(boundary_length);
      REG_BOUNDARY_WORD_0: prdata = boundary_word[0];
      REG_BOUNDARY_WORD_1: prdata = boundary_word[1];
      REG_BOUNDARY_WORD_2: prdata = boundary_word[2];
      REG_BOUNDARY_WORD_3: prdata = boundary_word[3];
      REG_BOUNDARY_WORD_4: prdata = boundary_word[4];
      REG_BOUNDARY_WORD_5: prdata = boundary_word[5];
      REG_BOUNDARY_WORD_6: prdata = boundary_word[6];
      default:             prdata = '0;
    endcase
  end

  // decode of the incoming byte against the current state
  assign data_byte  = s_tdata;
  assign buffer_end = s_tlast;
  assign is_cr      = (data_byte == CHAR_CR);
  assign is_lf      = (data_byte == CHAR_LF);
  assign is_dash    = (data_byte == CHAR_DASH);
  assign len_used   = (boundary_length > BLEN_BITS'(MAX_BOUNDARY_BYTES)) ?
                      BLEN_BITS'(MAX_BOUNDARY_BYTES) : boundary_length;
  // the top word slot does not exist, it is never read while a match is live
  assign word_sel   = (match_index[5:3] == 3'd7) ? 3'd0 : match_index[5:3];
  assign bnd_byte   = boundary_word[word_sel][{match_index[2:0], 3'b000} +: 8];
  assign match_inc  = {1'b0, match_index} + (BLEN_BITS+1)'(1);

  assign found = !is_cr && !is_lf &&
                 (((scan_phase == PH_DASH2) && is_dash && (len_used == '0)) ||
                  ((scan_phase == PH_BOUNDARY) && (match_index < len_used) &&
                   (data_byte == bnd_byte) && (match_inc >= {1'b0, len_used})));

  // next state
  always_comb begin
    scan_phase_next       = scan_phase;
    match_index_next      = match_index;
    byte_count_next       = byte_count;
    last_cr_position_next = last_cr_position;
    if (is_cr) begin
      scan_phase_next       = PH_EXPECT_LF;
      last_cr_position_next = byte_count;
    end else if (is_lf) begin
      scan_phase_next = (scan_phase == PH_EXPECT_LF) ? PH_DASH1 : PH_PARSING;
    end else begin
      case (scan_phase)
        PH_DASH1: begin
          scan_phase_next = is_dash ? PH_DASH2 : PH_PARSING;
        end
        PH_DASH2: begin
          if (is_dash) begin
            match_index_next = '0;
            scan_phase_next  = PH_BOUNDARY;
          end else begin
            scan_phase_next = PH_PARSING;
          end
        end
        PH_BOUNDARY: begin
          if ((match_index < len_used) && (data_byte == bnd_byte)) begin
            match_index_next = match_inc[BLEN_BITS-1:0];
          end else begin
            scan_phase_next = PH_PARSING;
          end
        end
        default: scan_phase_next = PH_PARSING;
      endcase
    end
    if (found || buffer_end) begin
      // restart for the next part
      scan_phase_next       = PH_PARSING;
      match_index_next      = '0;
      byte_count_next       = '0;
      last_cr_position_next = '0;
    end else if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + COUNT_BITS'(1);
    end
  end

  // result of this byte
  assign cr_ext = EXT_BITS'(last_cr_position);

  always_comb begin
    result.status         = ST_SCANNING;
    result.content_length = '0;
    if (found) begin
      result.status         = ST_FOUND;
      result.content_length = (cr_ext > EXT_BITS'(LEN_MAX)) ? LEN_MAX : cr_ext[LEN_BITS-1:0];
    end else if (buffer_end) begin
      result.status = ST_MISSING;
    end
  end

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= PH_PARSING;
      match_index      <= '0;
      byte_count       <= '0;
      last_cr_position <= '0;
    end else if (in_accept) begin
      scan_phase       <= scan_phase_next;
      match_index      <= match_index_next;
      byte_count       <= byte_count_next;
      last_cr_position <= last_cr_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= result;
      end
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data.content_length;
  assign m_tuser  = out_data.status;

endmodule
`default_nettype wire
